### sv/hierarchical_rank_mapper_core_assert.svh
// assertion macros used by the checker file hrm_checker.sv
`ifndef HIERARCHICAL_RANK_MAPPER_CORE_ASSERT_SVH
`define HIERARCHICAL_RANK_MAPPER_CORE_ASSERT_SVH

// property checked on every rising edge outside reset
`define HRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hrm assertion failed");

// property checked on every rising edge, reset included
`define HRM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hrm assertion failed");

`endif

### sv/hrm_pkg.sv
package hrm_pkg;

  localparam int unsigned HwLevels  = 3;
  localparam int unsigned MaxLevels = 3;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned ModSteps  = 32;
  localparam int unsigned ChainLen  = DivSteps + ModSteps + 1;
  localparam int unsigned NumStages = ChainLen + 2;
  localparam int unsigned AddrW     = 5;

  localparam logic CmdBuild   = 1'b0;
  localparam logic CmdExtract = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoLevel  = 2'd1;
  localparam logic [1:0] StatusZeroSize = 2'd2;

  localparam logic [2:0] RegLevelCount = 3'd0;
  localparam logic [2:0] RegOwnPosL0   = 3'd1;
  localparam logic [2:0] RegOwnPosL1   = 3'd2;
  localparam logic [2:0] RegOwnPosL2   = 3'd3;
  localparam logic [2:0] RegSizeL0     = 3'd4;
  localparam logic [2:0] RegSizeL1     = 3'd5;
  localparam logic [2:0] RegSizeL2     = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [31:0] rank_in;
    logic [1:0]  level;
  } in_t;

  typedef struct packed {
    logic [31:0] rank_out;
    logic [1:0]  status;
  } out_t;

  // one stage of the divide / modulo chain
  typedef struct packed {
    logic        cmd;
    logic [1:0]  status;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] acc;
    logic [31:0] dvs;
    logic [15:0] siz;
  } chain_t;

endpackage

### sv/hierarchical_rank_mapper_core.sv
// Mixed-radix rank mapper over up to three hierarchy levels, all arithmetic modulo 2^32.
// Command 0 builds a global rank from a sub-rank at the chosen level and this node's own
// positions at the other levels; command 1 extracts the sub-rank at the chosen level as
// (global / product of lower sizes) mod level size. Status 1 flags a level beyond the
// count in use, status 2 a zero size at (or, for extraction, below) the chosen level; on
// error rank_out is 0. Throughput is one transfer per clock unless the output stalls. The
// datapath has 67 register stages: one for status and the level-two weight product (size
// 0 times size 1), one for the digit-times-weight multipliers, a head stage that registers
// the build sum and loads the divider, then a one-bit-per-stage restoring divider (32
// stages) and a one-bit-per-stage modulo unit (32 stages); the result is read straight off
// the last modulo stage.
// Each stage holds its own valid bit, so empty stages fill while the output is stalled and
// input ready only drops when every stage is occupied. Registers sit on an APB-style port
// at byte address 4*index and must only be written while no transfer is in flight.
module hierarchical_rank_mapper_core #(
  parameter int unsigned MaxLevels = hrm_pkg::MaxLevels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hrm_pkg::in_t                   in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hrm_pkg::out_t                  out_data_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrm_pkg::AddrW-1:0]      paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned N = hrm_pkg::NumStages;
  localparam int unsigned C = hrm_pkg::ChainLen;

  // configuration registers
  logic [1:0]  level_count_q;
  logic [15:0] pos0_q, pos1_q, pos2_q;
  logic [15:0] size0_q, size1_q, size2_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= 2'd2;
      pos0_q        <= 16'd0;
      pos1_q        <= 16'd0;
      pos2_q        <= 16'd0;
      size0_q       <= 16'd1;
      size1_q       <= 16'd1;
      size2_q       <= 16'd1;
    end else if (wr_en) begin
      case (reg_idx)
        hrm_pkg::RegLevelCount: level_count_q <= pwdata[1:0];
        hrm_pkg::RegOwnPosL0:   pos0_q        <= pwdata[15:0];
        hrm_pkg::RegOwnPosL1:   pos1_q        <= pwdata[15:0];
        hrm_pkg::RegOwnPosL2:   pos2_q        <= pwdata[15:0];
        hrm_pkg::RegSizeL0:     size0_q       <= pwdata[15:0];
        hrm_pkg::RegSizeL1:     size1_q       <= pwdata[15:0];
        hrm_pkg::RegSizeL2:     size2_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hrm_pkg::RegLevelCount: prdata = {30'd0, level_count_q};
      hrm_pkg::RegOwnPosL0:   prdata = {16'd0, pos0_q};
      hrm_pkg::RegOwnPosL1:   prdata = {16'd0, pos1_q};
      hrm_pkg::RegOwnPosL2:   prdata = {16'd0, pos2_q};
      hrm_pkg::RegSizeL0:     prdata = {16'd0, size0_q};
      hrm_pkg::RegSizeL1:     prdata = {16'd0, size1_q};
      hrm_pkg::RegSizeL2:     prdata = {16'd0, size2_q};
      default:                prdata = 32'd0;
    endcase
  end

  // levels in use: level_count clipped to the build limit and the register count
  localparam int unsigned LvlCap = (MaxLevels < hrm_pkg::HwLevels) ?
                                   MaxLevels : hrm_pkg::HwLevels;
  logic [1:0] lvl_used;
  assign lvl_used = ({30'd0, level_count_q} > LvlCap) ? 2'(LvlCap) : level_count_q;

  // per-stage handshake: a stage may take a new item when it or any stage after it is
  // empty, or when the output is taken
  logic [N-1:0] v_q;
  logic [N-1:0] adv;

  for (genvar i = 0; i < N; i++) begin : g_adv
    assign adv[i] = out_ready_i | ~(&v_q[N-1:i]);
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < N; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 1: status, operands and the level-two weight
  logic        cmd1_q;
  logic [31:0] rank1_q;
  logic [1:0]  level1_q, stat1_q;
  logic [31:0] w2_q;
  logic [1:0]  stat1_d;
  logic [15:0] size_sel;
  logic        low_zero;

  always_comb begin
    case (in_data_i.level)
      2'd0:    size_sel = size0_q;
      2'd1:    size_sel = size1_q;
      2'd2:    size_sel = size2_q;
      default: size_sel = 16'd0;
    endcase
    // a zero size below the chosen level makes the extraction weight zero
    low_zero = ((in_data_i.level >= 2'd1) && (size0_q == 16'd0)) ||
               ((in_data_i.level >= 2'd2) && (size1_q == 16'd0));
    if (in_data_i.level >= lvl_used) begin
      stat1_d = hrm_pkg::StatusNoLevel;
    end else if ((size_sel == 16'd0) ||
                 ((in_data_i.cmd == hrm_pkg::CmdExtract) && low_zero)) begin
      stat1_d = hrm_pkg::StatusZeroSize;
    end else begin
      stat1_d = hrm_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cmd1_q   <= in_data_i.cmd;
      rank1_q  <= in_data_i.rank_in;
      level1_q <= in_data_i.level;
      stat1_q  <= stat1_d;
      w2_q     <= 32'(size0_q) * 32'(size1_q);
    end
  end

  // stage 2: digit times weight for each level, divisor and modulus selection
  logic        cmd2_q;
  logic [1:0]  stat2_q;
  logic [31:0] rank2_q, dvs2_q, t0_q, t1_q, t2_q;
  logic [15:0] siz2_q;
  logic [31:0] dig0, dig1, dig2, dvs2_d;
  logic [15:0] siz2_d;
  logic [47:0] prod1;
  logic [63:0] prod2;

  always_comb begin
    dig0  = (level1_q == 2'd0) ? rank1_q : {16'd0, pos0_q};
    dig1  = (level1_q == 2'd1) ? rank1_q : {16'd0, pos1_q};
    dig2  = (level1_q == 2'd2) ? rank1_q : {16'd0, pos2_q};
    prod1 = 48'(dig1) * 48'(size0_q);
    prod2 = 64'(dig2) * 64'(w2_q);
    case (level1_q)
      2'd0:    begin dvs2_d = 32'd1;           siz2_d = size0_q; end
      2'd1:    begin dvs2_d = {16'd0, size0_q}; siz2_d = size1_q; end
      2'd2:    begin dvs2_d = w2_q;            siz2_d = size2_q; end
      default: begin dvs2_d = 32'd1;           siz2_d = 16'd1;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      cmd2_q  <= cmd1_q;
      stat2_q <= stat1_q;
      rank2_q <= rank1_q;
      dvs2_q  <= dvs2_d;
      siz2_q  <= siz2_d;
      // levels not in use contribute nothing
      t0_q    <= (lvl_used > 2'd0) ? dig0 : 32'd0;
      t1_q    <= (lvl_used > 2'd1) ? prod1[31:0] : 32'd0;
      t2_q    <= (lvl_used > 2'd2) ? prod2[31:0] : 32'd0;
    end
  end

  // divide chain: head stage takes the sum, then one quotient bit per stage,
  // then one modulo step per stage on the quotient
  hrm_pkg::chain_t ch_q [C];
  hrm_pkg::chain_t ch_d [C];

  always_comb begin
    logic [32:0] r33;
    logic [16:0] r17;
    logic [15:0] rin;
    r33 = '0;
    r17 = '0;
    rin = '0;
    ch_d[0].cmd    = cmd2_q;
    ch_d[0].status = stat2_q;
    ch_d[0].res    = t0_q + t1_q + t2_q;
    ch_d[0].rem    = 32'd0;
    ch_d[0].acc    = rank2_q;
    ch_d[0].dvs    = dvs2_q;
    ch_d[0].siz    = siz2_q;
    for (int j = 1; j < C; j++) begin
      ch_d[j] = ch_q[j-1];
      if (j <= hrm_pkg::DivSteps) begin
        r33 = {ch_q[j-1].rem, ch_q[j-1].acc[31]};
        if (r33 >= {1'b0, ch_q[j-1].dvs}) begin
          ch_d[j].rem = 32'(r33 - {1'b0, ch_q[j-1].dvs});
          ch_d[j].acc = {ch_q[j-1].acc[30:0], 1'b1};
        end else begin
          ch_d[j].rem = r33[31:0];
          ch_d[j].acc = {ch_q[j-1].acc[30:0], 1'b0};
        end
      end else begin
        // the remainder restarts at zero once the quotient is complete
        rin = (j == hrm_pkg::DivSteps + 1) ? 16'd0 : ch_q[j-1].rem[15:0];
        r17 = {rin, ch_q[j-1].acc[31]};
        ch_d[j].acc = {ch_q[j-1].acc[30:0], 1'b0};
        if (r17 >= {1'b0, ch_q[j-1].siz}) begin
          ch_d[j].rem = {16'd0, 16'(r17 - {1'b0, ch_q[j-1].siz})};
        end else begin
          ch_d[j].rem = {16'd0, r17[15:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < C; j++) begin
      if (adv[j+2]) begin
        ch_q[j] <= ch_d[j];
      end
    end
  end

  // result formatting off the last chain register
  assign out_valid_o = v_q[N-1];

  always_comb begin
    out_data_o.status = ch_q[C-1].status;
    if (ch_q[C-1].status != hrm_pkg::StatusOk) begin
      out_data_o.rank_out = 32'd0;
    end else if (ch_q[C-1].cmd == hrm_pkg::CmdExtract) begin
      out_data_o.rank_out = {16'd0, ch_q[C-1].rem[15:0]};
    end else begin
      out_data_o.rank_out = ch_q[C-1].res;
    end
  end

endmodule

### sv/hrm_checker.sv
`include "hierarchical_rank_mapper_core_assert.svh"

module hrm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input hrm_pkg::out_t             out_data_o,
  input logic                      pready
);

  logic err_res;
  logic out_stall;

  assign err_res   = out_valid_o && (out_data_o.status != hrm_pkg::StatusOk);
  assign out_stall = out_valid_o && !out_ready_i;

  // an error result always carries a zero rank
  `HRM_ASSERT(a_err_zero, clk_i, rst_ni, err_res |-> (out_data_o.rank_out == 32'd0))

  // status code three is never produced
  `HRM_ASSERT(a_status_range, clk_i, rst_ni, out_valid_o |-> (out_data_o.status != 2'd3))

  // a held result stays until its transfer
  `HRM_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (out_valid_o && $stable(out_data_o)))

  // with no result waiting at the output the input side must be open
  `HRM_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // register port never waits
  `HRM_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind hierarchical_rank_mapper_core hrm_checker u_hrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
